@@ hdl/rrtt_pkg.sv @@
// ============================================================================
// rrtt_pkg
// Shared widths, codes and types of the round-robin task table.
// ============================================================================
package rrtt_pkg;

    localparam int SLOT_COUNT      = 128;
    localparam int PRIORITY_LEVELS = 8;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int PRIO_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

    localparam int OPC_W  = 3;
    localparam int TSLT_W = 7;
    localparam int CTX_W  = 64;
    localparam int LVL_W  = 3;
    localparam int STAT_W = 2;
    localparam int CMP_W  = 10;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_KILLED  = 2'd3
    } t_slot_state;

    typedef enum logic [OPC_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_KILL     = 3'd2,
        OP_BLOCK    = 3'd3,
        OP_SET_PRIO = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        RS_OK       = 2'd0,
        RS_BAD_SLOT = 2'd1,
        RS_BAD_PRIO = 2'd2
    } t_result;

    typedef struct packed {
        logic                st_we;
        logic                pr_we;
        logic [SLOT_W-1:0]   addr;
        t_slot_state         st;
        logic [PRIO_W-1:0]   pr;
    } t_slot_wr;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOT_COUNT - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

@@ hdl/rrtt_ram.sv @@
// ============================================================================
// rrtt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rrtt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rrtt_slot_mem.sv @@
// ============================================================================
// rrtt_slot_mem
// Slot status memory with per-entry valid bits (empty after reset) and the
// slot priority store. Registered status read.
// ============================================================================
module rrtt_slot_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rrtt_pkg::SLOT_W-1:0]    i_rd_addr,
    output rrtt_pkg::t_slot_state          o_rd_status,
    input  rrtt_pkg::t_slot_wr             i_wr
);

    rrtt_pkg::t_slot_state           r_status [rrtt_pkg::SLOT_COUNT];
    logic [rrtt_pkg::PRIO_W-1:0]     r_prio   [rrtt_pkg::SLOT_COUNT];
    logic [rrtt_pkg::SLOT_COUNT-1:0] r_vld;
    rrtt_pkg::t_slot_state           r_rd_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.st_we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.st_we) begin
            r_status[i_wr.addr] <= i_wr.st;
        end
        if (i_wr.pr_we) begin
            r_prio[i_wr.addr] <= i_wr.pr;
        end
        r_rd_status <= r_vld[i_rd_addr] ? r_status[i_rd_addr] : rrtt_pkg::ST_EMPTY;
    end

    assign o_rd_status = r_rd_status;

endmodule

@@ hdl/round_robin_task_table.sv @@
// ============================================================================
// round_robin_task_table
// Task slot table with create, round-robin schedule, kill, block toggle and
// set priority. Status and context live in memories with registered read data.
// ============================================================================
// Create scans the slots for an empty one; schedule and self kill scan for the
//   next ready slot (one status read per slot in the scan).
// Throughput: one item at a time; the next word is taken once the result is
//   in the output register.
// Reset: synchronous, active low; all slots empty, current slot 0, idle slot 0.
module round_robin_task_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrtt_pkg::TSLT_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rrtt_pkg::OPC_W-1:0]  i_opcode,
    input  logic [rrtt_pkg::TSLT_W-1:0] i_target_slot,
    input  logic [rrtt_pkg::CTX_W-1:0]  i_context_word,
    input  logic [rrtt_pkg::LVL_W-1:0]  i_priority_level,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rrtt_pkg::STAT_W-1:0] o_status,
    output logic [rrtt_pkg::TSLT_W-1:0] o_result_slot,
    output logic [rrtt_pkg::CTX_W-1:0]  o_next_context,
    output logic                        o_switched
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE_RD,
        S_PROBE,
        S_CREATE,
        S_SCAN,
        S_CTX_RD,
        S_CTX,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [rrtt_pkg::TSLT_W-1:0] r_idle, n_idle;
    logic [rrtt_pkg::SLOT_W-1:0] r_cur, n_cur;
    logic [rrtt_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic [rrtt_pkg::SLOT_W-1:0] r_chk_idx, n_chk_idx;
    logic                        r_chk, n_chk;
    logic [rrtt_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    rrtt_pkg::t_opcode           r_op, n_op;
    logic [rrtt_pkg::TSLT_W-1:0] r_tgt, n_tgt;
    logic [rrtt_pkg::CTX_W-1:0]  r_word, n_word;
    logic [rrtt_pkg::LVL_W-1:0]  r_lvl, n_lvl;

    rrtt_pkg::t_result           r_res_status, n_res_status;
    logic [rrtt_pkg::TSLT_W-1:0] r_res_slot, n_res_slot;
    logic                        r_res_new, n_res_new;
    logic [rrtt_pkg::CTX_W-1:0]  r_res_ctx, n_res_ctx;
    logic                        r_res_sw, n_res_sw;

    logic                        r_out_valid, n_out_valid;
    logic [rrtt_pkg::STAT_W-1:0] r_out_status, n_out_status;
    logic [rrtt_pkg::TSLT_W-1:0] r_out_slot, n_out_slot;
    logic [rrtt_pkg::CTX_W-1:0]  r_out_ctx, n_out_ctx;
    logic                        r_out_sw, n_out_sw;

    logic [rrtt_pkg::SLOT_W-1:0] st_rd_addr;
    rrtt_pkg::t_slot_state       st_rd;
    rrtt_pkg::t_slot_wr          slot_wr;
    logic                        ctx_we;
    logic [rrtt_pkg::SLOT_W-1:0] ctx_waddr;
    logic [rrtt_pkg::CTX_W-1:0]  ctx_wdata;
    logic [rrtt_pkg::CTX_W-1:0]  ctx_rdata;

    logic                        tgt_bad;
    logic                        idle_in_range;
    logic [rrtt_pkg::SLOT_W-1:0] tgt_slot;
    logic [rrtt_pkg::SLOT_W-1:0] idle_slot;
    logic                        scan_end;

    rrtt_slot_mem u_slot_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (st_rd_addr),
        .o_rd_status (st_rd),
        .i_wr        (slot_wr)
    );

    rrtt_ram #(
        .WIDTH (rrtt_pkg::CTX_W),
        .DEPTH (rrtt_pkg::SLOT_COUNT)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ctx_we),
        .i_waddr (ctx_waddr),
        .i_wdata (ctx_wdata),
        .i_raddr (r_cur),
        .o_rdata (ctx_rdata)
    );

    assign tgt_slot      = rrtt_pkg::SLOT_W'(r_tgt);
    assign idle_slot     = rrtt_pkg::SLOT_W'(r_idle);
    assign idle_in_range = rrtt_pkg::CMP_W'(r_idle) < rrtt_pkg::CMP_W'(rrtt_pkg::SLOT_COUNT);
    assign tgt_bad       = (rrtt_pkg::CMP_W'(r_tgt) >= rrtt_pkg::CMP_W'(rrtt_pkg::SLOT_COUNT))
                        || (r_tgt == r_idle) || (st_rd == rrtt_pkg::ST_EMPTY);
    assign scan_end      = r_cnt == rrtt_pkg::CNT_W'(rrtt_pkg::SLOT_COUNT);

    always_comb begin
        n_state      = r_state;
        n_idle       = r_idle;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_chk_idx    = r_chk_idx;
        n_chk        = r_chk;
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_tgt        = r_tgt;
        n_word       = r_word;
        n_lvl        = r_lvl;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_new    = r_res_new;
        n_res_ctx    = r_res_ctx;
        n_res_sw     = r_res_sw;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_ctx    = r_out_ctx;
        n_out_sw     = r_out_sw;

        st_rd_addr   = r_idx;
        slot_wr      = '{st_we: 1'b0, pr_we: 1'b0, addr: r_chk_idx,
                         st: rrtt_pkg::ST_EMPTY, pr: '0};
        ctx_we       = 1'b0;
        ctx_waddr    = r_cur;
        ctx_wdata    = r_word;

        if (i_cfg_we) begin
            n_idle = i_cfg_wdata;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = rrtt_pkg::t_opcode'(i_opcode);
                    n_tgt        = i_target_slot;
                    n_word       = i_context_word;
                    n_lvl        = i_priority_level;
                    n_res_status = rrtt_pkg::RS_OK;
                    n_res_new    = 1'b0;
                    n_res_ctx    = '0;
                    n_res_sw     = 1'b0;
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_chk        = 1'b0;
                    unique case (rrtt_pkg::t_opcode'(i_opcode))
                        rrtt_pkg::OP_CREATE:   n_state = S_CREATE;
                        rrtt_pkg::OP_SCHEDULE,
                        rrtt_pkg::OP_KILL,
                        rrtt_pkg::OP_BLOCK,
                        rrtt_pkg::OP_SET_PRIO: n_state = S_PROBE_RD;
                        default: begin
                            n_res_status = rrtt_pkg::RS_BAD_SLOT;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_PROBE_RD: begin
                st_rd_addr = (r_op == rrtt_pkg::OP_SCHEDULE) ? r_cur : tgt_slot;
                n_state    = S_PROBE;
            end
            S_PROBE: begin
                n_idx   = rrtt_pkg::next_slot(r_cur);
                n_cnt   = '0;
                n_chk   = 1'b0;
                n_state = S_DONE;
                if (r_op == rrtt_pkg::OP_SCHEDULE) begin
                    ctx_we  = st_rd != rrtt_pkg::ST_EMPTY;
                    n_state = S_SCAN;
                end else if (tgt_bad) begin
                    n_res_status = rrtt_pkg::RS_BAD_SLOT;
                end else begin
                    slot_wr.addr = tgt_slot;
                    unique case (r_op)
                        rrtt_pkg::OP_KILL: begin
                            slot_wr.st_we = 1'b1;
                            slot_wr.st    = rrtt_pkg::ST_KILLED;
                            if (tgt_slot == r_cur) begin
                                ctx_we    = 1'b1;
                                ctx_wdata = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        rrtt_pkg::OP_BLOCK: begin
                            if (st_rd == rrtt_pkg::ST_READY) begin
                                slot_wr.st_we = 1'b1;
                                slot_wr.st    = rrtt_pkg::ST_BLOCKED;
                            end else if (st_rd == rrtt_pkg::ST_BLOCKED) begin
                                slot_wr.st_we = 1'b1;
                                slot_wr.st    = rrtt_pkg::ST_READY;
                            end
                        end
                        rrtt_pkg::OP_SET_PRIO: begin
                            if (rrtt_pkg::CMP_W'(r_lvl)
                                    >= rrtt_pkg::CMP_W'(rrtt_pkg::PRIORITY_LEVELS)) begin
                                n_res_status = rrtt_pkg::RS_BAD_PRIO;
                            end else begin
                                slot_wr.pr_we = 1'b1;
                                slot_wr.pr    = rrtt_pkg::PRIO_W'(r_lvl);
                            end
                        end
                        default: begin
                            n_res_status = rrtt_pkg::RS_BAD_SLOT;
                        end
                    endcase
                end
            end
            S_CREATE: begin
                priority if (r_chk && st_rd == rrtt_pkg::ST_EMPTY) begin
                    slot_wr.st_we = 1'b1;
                    slot_wr.pr_we = 1'b1;
                    slot_wr.st    = rrtt_pkg::ST_READY;
                    slot_wr.pr    = '0;
                    ctx_we        = 1'b1;
                    ctx_waddr     = r_chk_idx;
                    n_res_slot    = rrtt_pkg::TSLT_W'(r_chk_idx);
                    n_res_new     = 1'b1;
                    n_state       = S_DONE;
                end else if (scan_end) begin
                    n_res_status = rrtt_pkg::RS_BAD_SLOT;
                    n_state      = S_DONE;
                end else begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx;
                    n_idx     = rrtt_pkg::next_slot(r_idx);
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            S_SCAN: begin
                if (r_chk && st_rd == rrtt_pkg::ST_READY) begin
                    n_cur   = r_chk_idx;
                    n_state = S_CTX_RD;
                end else begin
                    if (r_chk && st_rd == rrtt_pkg::ST_KILLED) begin
                        slot_wr.st_we = 1'b1;
                        slot_wr.st    = rrtt_pkg::ST_EMPTY;
                    end
                    if (scan_end) begin
                        if (idle_in_range) begin
                            n_cur   = idle_slot;
                            n_state = S_CTX_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_chk     = 1'b1;
                        n_chk_idx = r_idx;
                        n_idx     = rrtt_pkg::next_slot(r_idx);
                        n_cnt     = r_cnt + 1'b1;
                    end
                end
            end
            S_CTX_RD: begin
                n_state = S_CTX;
            end
            S_CTX: begin
                n_res_ctx = ctx_rdata;
                n_res_sw  = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_new ? r_res_slot : rrtt_pkg::TSLT_W'(r_cur);
                    n_out_ctx    = r_res_ctx;
                    n_out_sw     = r_res_sw;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle      <= '0;
            r_cur       <= '0;
            r_chk       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idle      <= n_idle;
            r_cur       <= n_cur;
            r_chk       <= n_chk;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_op         <= n_op;
        r_tgt        <= n_tgt;
        r_word       <= n_word;
        r_lvl        <= n_lvl;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_new    <= n_res_new;
        r_res_ctx    <= n_res_ctx;
        r_res_sw     <= n_res_sw;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_ctx    <= n_out_ctx;
        r_out_sw     <= n_out_sw;
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_slot  = r_out_slot;
    assign o_next_context = r_out_ctx;
    assign o_switched     = r_out_sw;

endmodule

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for the round-robin task table: a queue-fed driver
// with bursty valid, a receiver with patterned stall, and a command-level
// predictor of the slot table that checks every result word field by field.
// ============================================================================
module tb_top;
    import rrtt_pkg::*;

    localparam int ACCEPT_SIDE = 0;
    localparam int PLAN_SIDE   = 1;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [OPC_W-1:0]  op;
        logic [TSLT_W-1:0] tgt;
        logic [CTX_W-1:0]  ctx;
        logic [LVL_W-1:0]  lvl;
    } task_cmd_t;

    typedef struct packed {
        t_result           status;
        logic [TSLT_W-1:0] slot;
        logic [CTX_W-1:0]  nctx;
        logic              sw;
    } table_reply_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [TSLT_W-1:0]   i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OPC_W-1:0]    i_opcode = '0;
    logic [TSLT_W-1:0]   i_target_slot = '0;
    logic [CTX_W-1:0]    i_context_word = '0;
    logic [LVL_W-1:0]    i_priority_level = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [TSLT_W-1:0]   o_result_slot;
    logic [CTX_W-1:0]    o_next_context;
    logic                o_switched;

    t_slot_state         tbl_state  [2][SLOT_COUNT];
    logic [CTX_W-1:0]    tbl_ctx    [2][SLOT_COUNT];
    logic [PRIO_W-1:0]   tbl_level  [2][SLOT_COUNT];
    bit                  tbl_ctx_set[2][SLOT_COUNT];
    logic [SLOT_W-1:0]   run_slot   [2];
    logic [TSLT_W-1:0]   idle_sel   [2];

    task_cmd_t           pending_cmds[$];
    table_reply_t        predicted_replies[$];
    int                  err_cnt = 0;

    bit                  word_taken;
    int                  burst_left = 8;
    int                  gap_left = 0;
    rx_mode_t            rx_mode = RX_FREE;
    int                  mode_left = 0;
    int                  rx_tick = 0;
    bit                  rx_stall_bit;
    int                  rx_hold_left = 0;
    bit                  rx_hold_req = 1'b0;
    bit                  rx_hold_ack = 1'b0;

    round_robin_task_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_target_slot    (i_target_slot),
        .i_context_word   (i_context_word),
        .i_priority_level (i_priority_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_result_slot    (o_result_slot),
        .o_next_context   (o_next_context),
        .o_switched       (o_switched)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit rr_select(int m, logic [CTX_W-1:0] saved,
                                     output logic [CTX_W-1:0] sel_ctx);
        int  s;
        bit  found;
        found   = 1'b0;
        sel_ctx = '0;
        if (int'(run_slot[m]) < SLOT_COUNT && tbl_state[m][run_slot[m]] != ST_EMPTY) begin
            tbl_ctx[m][run_slot[m]]     = saved;
            tbl_ctx_set[m][run_slot[m]] = 1'b1;
        end
        for (int i = 0; i < SLOT_COUNT && !found; i++) begin
            s = (int'(run_slot[m]) + i + 1) % SLOT_COUNT;
            if (tbl_state[m][s] == ST_READY) begin
                run_slot[m] = SLOT_W'(s);
                sel_ctx     = tbl_ctx[m][s];
                found       = 1'b1;
            end else if (tbl_state[m][s] == ST_KILLED) begin
                tbl_state[m][s] = ST_EMPTY;
            end
        end
        if (!found && int'(idle_sel[m]) < SLOT_COUNT) begin
            run_slot[m] = SLOT_W'(idle_sel[m]);
            sel_ctx     = tbl_ctx[m][idle_sel[m]];
            found       = 1'b1;
        end
        return found;
    endfunction

    function automatic table_reply_t apply_cmd(int m, task_cmd_t c);
        table_reply_t      r;
        logic [CTX_W-1:0]  sel;
        bit                tgt_ok;
        bit                slot_fixed;
        int                s;
        r          = '0;
        sel        = '0;
        slot_fixed = 1'b0;
        tgt_ok     = int'(c.tgt) < SLOT_COUNT && c.tgt != idle_sel[m]
                     && tbl_state[m][c.tgt] != ST_EMPTY;
        case (c.op)
            OP_CREATE: begin
                s = 0;
                while (s < SLOT_COUNT && tbl_state[m][s] != ST_EMPTY) s++;
                if (s == SLOT_COUNT) begin
                    r.status = RS_BAD_SLOT;
                end else begin
                    tbl_state[m][s]   = ST_READY;
                    tbl_ctx[m][s]     = c.ctx;
                    tbl_ctx_set[m][s] = 1'b1;
                    tbl_level[m][s]   = '0;
                    r.slot            = TSLT_W'(s);
                    slot_fixed        = 1'b1;
                end
            end
            OP_SCHEDULE: begin
                r.sw = rr_select(m, c.ctx, sel);
            end
            OP_KILL: begin
                if (!tgt_ok) begin
                    r.status = RS_BAD_SLOT;
                end else begin
                    tbl_state[m][c.tgt] = ST_KILLED;
                    if (c.tgt == run_slot[m]) r.sw = rr_select(m, '0, sel);
                end
            end
            OP_BLOCK: begin
                if (!tgt_ok) begin
                    r.status = RS_BAD_SLOT;
                end else if (tbl_state[m][c.tgt] == ST_READY) begin
                    tbl_state[m][c.tgt] = ST_BLOCKED;
                end else if (tbl_state[m][c.tgt] == ST_BLOCKED) begin
                    tbl_state[m][c.tgt] = ST_READY;
                end
            end
            OP_SET_PRIO: begin
                if (!tgt_ok) begin
                    r.status = RS_BAD_SLOT;
                end else if (int'(c.lvl) >= PRIORITY_LEVELS) begin
                    r.status = RS_BAD_PRIO;
                end else begin
                    tbl_level[m][c.tgt] = PRIO_W'(c.lvl);
                end
            end
            default: begin
                r.status = RS_BAD_SLOT;
            end
        endcase
        if (!slot_fixed) r.slot = TSLT_W'(run_slot[m]);
        r.nctx = r.sw ? sel : '0;
        return r;
    endfunction

    function automatic task_cmd_t cmd_of(logic [OPC_W-1:0] op, logic [TSLT_W-1:0] tgt,
                                         logic [CTX_W-1:0] ctx, logic [LVL_W-1:0] lvl);
        task_cmd_t c;
        c.op  = op;
        c.tgt = tgt;
        c.ctx = ctx;
        c.lvl = lvl;
        return c;
    endfunction

    function automatic task_cmd_t make_cmd(int create_pct);
        task_cmd_t c;
        int        p;
        int        start;
        int        s;
        bit        hit;
        c.ctx = {$urandom, $urandom};
        p = $urandom_range(9);
        if (p == 0) c.ctx = '0;
        if (p == 1) c.ctx = '1;
        c.lvl = LVL_W'($urandom_range((1 << LVL_W) - 1));
        p = $urandom_range(99);
        if (p < create_pct) begin
            c.op = OP_CREATE;
        end else begin
            p = $urandom_range(99);
            if (p < 30)      c.op = OP_SCHEDULE;
            else if (p < 50) c.op = OP_KILL;
            else if (p < 70) c.op = OP_BLOCK;
            else if (p < 90) c.op = OP_SET_PRIO;
            else c.op = OPC_W'($urandom_range(OP_SET_PRIO + 1, (1 << OPC_W) - 1));
        end
        p = $urandom_range(99);
        if (p < 10) begin
            c.tgt = TSLT_W'(run_slot[PLAN_SIDE]);
        end else if (p < 25) begin
            c.tgt = TSLT_W'($urandom_range((1 << TSLT_W) - 1));
        end else begin
            start = $urandom_range(SLOT_COUNT - 1);
            c.tgt = TSLT_W'(start);
            hit   = 1'b0;
            for (int i = 0; i < SLOT_COUNT && !hit; i++) begin
                s = (start + i) % SLOT_COUNT;
                if (tbl_state[PLAN_SIDE][s] != ST_EMPTY && TSLT_W'(s) != idle_sel[PLAN_SIDE]) begin
                    c.tgt = TSLT_W'(s);
                    hit   = 1'b1;
                end
            end
        end
        return c;
    endfunction

    // Turn a switch that would land on a never-written idle context into a create.
    task automatic queue_cmd(task_cmd_t c);
        bit self_kill;
        bit any_ready;
        self_kill = c.op == OP_KILL && int'(c.tgt) < SLOT_COUNT && c.tgt != idle_sel[PLAN_SIDE]
                    && tbl_state[PLAN_SIDE][c.tgt] != ST_EMPTY && c.tgt == run_slot[PLAN_SIDE];
        if ((c.op == OP_SCHEDULE || self_kill) && !tbl_ctx_set[PLAN_SIDE][idle_sel[PLAN_SIDE]]) begin
            any_ready = 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (tbl_state[PLAN_SIDE][s] == ST_READY && !(self_kill && TSLT_W'(s) == c.tgt))
                    any_ready = 1'b1;
            end
            if (!any_ready) c.op = OP_CREATE;
        end
        void'(apply_cmd(PLAN_SIDE, c));
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || predicted_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_idle_slot(logic [TSLT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        idle_sel[ACCEPT_SIDE] = v;
        idle_sel[PLAN_SIDE]   = v;
    endtask

    task automatic run_phase(logic [TSLT_W-1:0] idle, int n, int create_pct, bit long_hold);
        write_idle_slot(idle);
        if (long_hold) rx_hold_req = ~rx_hold_req;
        for (int i = 0; i < n / 2; i++) queue_cmd(make_cmd(create_pct));
        wait_drained();
        for (int i = n / 2; i < n; i++) queue_cmd(make_cmd(create_pct));
        wait_drained();
    endtask

    task automatic report_mismatch(string what, logic [CTX_W-1:0] got, logic [CTX_W-1:0] want);
        $display("[%0t] ERROR %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    initial begin
        for (int m = 0; m < 2; m++) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                tbl_state[m][s]   = ST_EMPTY;
                tbl_ctx[m][s]     = '0;
                tbl_level[m][s]   = '0;
                tbl_ctx_set[m][s] = 1'b0;
            end
            run_slot[m] = '0;
            idle_sel[m] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_idle_slot('0);
        queue_cmd(cmd_of(OP_CREATE, '0, '1, '0));
        queue_cmd(cmd_of(OP_CREATE, '1, '0, '1));
        queue_cmd(cmd_of(OP_CREATE, '0, 64'hA5A5_5A5A_F00D_0FF0, '0));
        queue_cmd(cmd_of(OP_SCHEDULE, '0, {$urandom, $urandom}, '0));
        queue_cmd(cmd_of(OP_KILL, '0, '0, '0));
        queue_cmd(cmd_of(OP_KILL, '1, '0, '0));
        queue_cmd(cmd_of(OP_BLOCK, '1, '0, '0));
        queue_cmd(cmd_of(OP_SET_PRIO, '1, '0, '1));
        queue_cmd(cmd_of(OP_SET_PRIO, TSLT_W'(2), '0, '1));
        queue_cmd(cmd_of(OP_SET_PRIO, TSLT_W'(1), '1, '0));
        queue_cmd(cmd_of(OP_BLOCK, TSLT_W'(2), '0, '0));
        queue_cmd(cmd_of(OP_KILL, TSLT_W'(1), '1, '0));
        queue_cmd(cmd_of(OP_BLOCK, TSLT_W'(1), '0, '0));
        queue_cmd(cmd_of(OP_SCHEDULE, '0, {$urandom, $urandom}, '0));
        queue_cmd(cmd_of(OP_BLOCK, TSLT_W'(2), '0, '0));
        for (int k = OP_SET_PRIO + 1; k < (1 << OPC_W); k++) begin
            queue_cmd(cmd_of(OPC_W'(k), TSLT_W'($urandom), {$urandom, $urandom},
                             LVL_W'($urandom)));
        end
        queue_cmd(cmd_of(OP_SCHEDULE, '0, {$urandom, $urandom}, '0));
        wait_drained();

        // idle now points at an empty slot whose context was saved by the self kill
        write_idle_slot(TSLT_W'(1));
        queue_cmd(cmd_of(OP_BLOCK, TSLT_W'(0), '0, '0));
        queue_cmd(cmd_of(OP_BLOCK, TSLT_W'(2), '0, '0));
        queue_cmd(cmd_of(OP_SCHEDULE, '0, '1, '0));
        queue_cmd(cmd_of(OP_SCHEDULE, '0, {$urandom, $urandom}, '0));
        wait_drained();

        run_phase('1, 400, 25, 1'b0);
        run_phase(TSLT_W'($urandom_range(2, SLOT_COUNT - 2)), 450, 65, 1'b1);
        run_phase('0, 400, 20, 1'b0);
        run_phase(TSLT_W'($urandom_range(SLOT_COUNT - 1)), 380, 35, 1'b0);

        repeat (SLOT_COUNT + 16) @(posedge i_clk);
        if (predicted_replies.size() != 0)
            report_mismatch("results never delivered", predicted_replies.size(), '0);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            word_taken = i_in_valid && !o_in_stall;
            if (word_taken) predicted_replies.push_back(apply_cmd(ACCEPT_SIDE, pending_cmds.pop_front()));
            if (i_in_valid && !word_taken) begin
                // hold the stalled word
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                i_in_valid       <= 1'b1;
                i_opcode         <= pending_cmds[0].op;
                i_target_slot    <= pending_cmds[0].tgt;
                i_context_word   <= pending_cmds[0].ctx;
                i_priority_level <= pending_cmds[0].lvl;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req != rx_hold_ack) begin
            rx_hold_left <= LONG_HOLD;
            rx_hold_ack  <= rx_hold_req;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_FREE:     rx_stall_bit = 1'b0;
                RX_LIGHT:    rx_stall_bit = $urandom_range(3) == 0;
                RX_HEAVY:    rx_stall_bit = $urandom_range(3) != 0;
                default:     rx_stall_bit = (rx_tick % 5) < 2;
            endcase
            i_out_stall <= (rx_hold_left != 0) || rx_stall_bit;
        end
    end

    always @(posedge i_clk) begin
        table_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("result word with none expected, slot", o_result_slot, '0);
            end else begin
                want = predicted_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_result_slot !== want.slot)
                    report_mismatch("result_slot", o_result_slot, want.slot);
                if (o_next_context !== want.nctx)
                    report_mismatch("next_context", o_next_context, want.nctx);
                if (o_switched !== want.sw)
                    report_mismatch("switched", o_switched, want.sw);
            end
        end
    end

endmodule
